FILE: rtl/spc_pkg.sv
// shared types and constants for the sprite camera projection block
package spc_pkg;

  localparam int SCREEN_W_DEF = 1024;
  localparam int TEX_RES_DEF  = 64;
  localparam int STORE_DEPTH  = 1024;
  localparam int DVD_W        = 47;
  localparam int DVS_W        = 33;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_PROJECT = 2'd1,
    KIND_TEST    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_DIR_X       = 3'd0,
    REG_DIR_Y       = 3'd1,
    REG_PLANE_X     = 3'd2,
    REG_PLANE_Y     = 3'd3,
    REG_PLAYER_X    = 3'd4,
    REG_PLAYER_Y    = 3'd5,
    REG_VIEW_HEIGHT = 3'd6,
    REG_HUD_TOP     = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    DIV_DEPTH  = 2'd0,
    DIV_CENTRE = 2'd1,
    DIV_HEIGHT = 2'd2,
    DIV_TEX    = 2'd3
  } div_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DEPTH,
    ST_DEPTH_W,
    ST_CTR,
    ST_CTR_W,
    ST_HGT,
    ST_HGT_W,
    ST_PROJ_OUT,
    ST_TEX,
    ST_TEX_W,
    ST_TEST_OUT
  } state_e;

  typedef struct packed {
    logic    in_take;
    logic    mul_en;
    logic    sum_en;
    logic    div_start;
    logic    div_take;
    div_op_e div_op;
    logic    proj_commit;
    logic    test_commit;
  } spc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_hold;
  } spc_sts_t;

endpackage

FILE: rtl/spc_div.sv
// unsigned restoring divider, one quotient bit per cycle
module spc_div
  import spc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] trial;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quo_q[DVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // keep the trial difference when it does not go negative
      if (!trial[DVS_W+1]) begin
        rem_d = trial[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

FILE: rtl/spc_ctrl.sv
// sequencer for write, project and test items
module spc_ctrl
  import spc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] kind_i,
  output logic       in_stall_o,
  output spc_cmd_t   cmd_o,
  input  spc_sts_t   sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_op = DIV_DEPTH;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_take = 1'b1;
          unique case (kind_e'(kind_i))
            KIND_PROJECT: state_d = ST_MUL;
            KIND_TEST:    state_d = ST_TEX;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d = ST_DEPTH;
      end
      ST_DEPTH: begin
        cmd_o.div_op    = DIV_DEPTH;
        cmd_o.div_start = 1'b1;
        state_d = ST_DEPTH_W;
      end
      ST_DEPTH_W: begin
        cmd_o.div_op = DIV_DEPTH;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = ST_CTR;
        end
      end
      ST_CTR: begin
        cmd_o.div_op    = DIV_CENTRE;
        cmd_o.div_start = 1'b1;
        state_d = ST_CTR_W;
      end
      ST_CTR_W: begin
        cmd_o.div_op = DIV_CENTRE;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = ST_HGT;
        end
      end
      ST_HGT: begin
        cmd_o.div_op    = DIV_HEIGHT;
        cmd_o.div_start = 1'b1;
        state_d = ST_HGT_W;
      end
      ST_HGT_W: begin
        cmd_o.div_op = DIV_HEIGHT;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = ST_PROJ_OUT;
        end
      end
      ST_PROJ_OUT: begin
        if (!sts_i.out_hold) begin
          cmd_o.proj_commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_TEX: begin
        cmd_o.div_op    = DIV_TEX;
        cmd_o.div_start = 1'b1;
        state_d = ST_TEX_W;
      end
      ST_TEX_W: begin
        cmd_o.div_op = DIV_TEX;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = ST_TEST_OUT;
        end
      end
      ST_TEST_OUT: begin
        if (!sts_i.out_hold) begin
          cmd_o.test_commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

FILE: rtl/spc_dp.sv
// datapath: camera transform, shared divider, depth store and result register
module spc_dp
  import spc_pkg::*;
#(
  parameter int SCREEN_W = SCREEN_W_DEF,
  parameter int TEX_RES  = TEX_RES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spc_cmd_t           cmd_i,
  output spc_sts_t           sts_o,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] plane_x_i,
  input  logic signed [15:0] plane_y_i,
  input  logic [15:0]        player_x_i,
  input  logic [15:0]        player_y_i,
  input  logic [10:0]        view_height_i,
  input  logic [10:0]        hud_top_i,
  input  logic [1:0]         kind_i,
  input  logic [9:0]         column_i,
  input  logic [15:0]        wall_depth_i,
  input  logic [15:0]        entity_x_i,
  input  logic [15:0]        entity_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] centre_x_o,
  output logic signed [15:0] left_x_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] top_y_o,
  output logic signed [15:0] bottom_y_o,
  output logic [33:0]        sq_distance_o,
  output logic               behind_o,
  output logic [5:0]         tex_column_o,
  output logic               draw_o
);

  localparam int HALF_W = SCREEN_W / 2;
  localparam int CW     = 21;
  localparam int CLAMP  = 1 << 18;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // item registers
  logic [9:0]         col_q;
  logic signed [16:0] rx_q, ry_q, rx_d, ry_d;

  // products and sums
  logic signed [31:0] p_det1_q, p_det2_q;
  logic signed [32:0] p_a1_q, p_a2_q, p_b1_q, p_b2_q;
  logic signed [33:0] p_sx_q, p_sy_q;
  logic signed [32:0] det_q;
  logic signed [33:0] a_q, b_q;
  logic [33:0]        sq_q;
  logic [32:0]        abs_a, abs_b, abs_det;

  // sprite state and quotient results
  logic signed [31:0] depth_q;
  logic signed [15:0] left_q, right_q;
  logic signed [CW-1:0] centre_q, centre_d;
  logic [14:0]        half_q;
  logic [5:0]         tex_q;
  logic [31:0]        mag;

  // divider hookup
  logic [DVD_W-1:0] dvd, quo;
  logic [DVS_W-1:0] dvs;
  logic             div_done;
  logic [18:0]      qc;
  logic signed [CW-1:0] qs;

  // column test
  logic signed [17:0] diff;
  logic signed [16:0] span, col_s;
  logic [24:0]        tex_num;
  logic               in_extent, in_screen, draw_d;

  // depth store
  logic [15:0] mem [STORE_DEPTH];
  logic [15:0] rd_q;

  // result
  logic               out_valid_q;
  logic signed [21:0] c22, h22, hz22;

  assign rx_d = $signed({1'b0, entity_x_i}) - $signed({1'b0, player_x_i});
  assign ry_d = $signed({1'b0, entity_y_i}) - $signed({1'b0, player_y_i});

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      col_q <= column_i;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
    end
    if (cmd_i.mul_en) begin
      p_det1_q <= plane_x_i * dir_y_i;
      p_det2_q <= dir_x_i * plane_y_i;
      p_a1_q   <= dir_y_i * rx_q;
      p_a2_q   <= dir_x_i * ry_q;
      p_b1_q   <= plane_x_i * ry_q;
      p_b2_q   <= plane_y_i * rx_q;
      p_sx_q   <= rx_q * rx_q;
      p_sy_q   <= ry_q * ry_q;
    end
    if (cmd_i.sum_en) begin
      det_q <= p_det1_q - p_det2_q;
      a_q   <= p_a1_q - p_a2_q;
      b_q   <= p_b1_q - p_b2_q;
      sq_q  <= $unsigned(p_sx_q) + $unsigned(p_sy_q);
    end
  end

  assign abs_a   = a_q[33] ? 33'(-a_q) : a_q[32:0];
  assign abs_b   = b_q[33] ? 33'(-b_q) : b_q[32:0];
  assign abs_det = det_q[32] ? 33'(-det_q) : 33'(det_q);
  assign mag     = depth_q[31] ? 32'(-depth_q) : 32'(depth_q);

  assign col_s   = $signed({7'd0, col_q});
  assign diff    = $signed({8'd0, col_q}) - left_q;
  assign span    = right_q - left_q;
  assign tex_num = 25'(diff[16:0]) * 25'(TEX_RES);

  always_comb begin
    unique case (cmd_i.div_op)
      DIV_DEPTH: begin
        dvd = {abs_b, 14'd0};
        dvs = abs_det;
      end
      DIV_CENTRE: begin
        dvd = DVD_W'(abs_a) * DVD_W'(HALF_W);
        dvs = abs_b;
      end
      DIV_HEIGHT: begin
        dvd = DVD_W'({view_height_i, 8'd0});
        dvs = DVS_W'(mag);
      end
      DIV_TEX: begin
        dvd = DVD_W'(tex_num);
        dvs = DVS_W'(span[16:0]);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  spc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // centre column: clamp is wide enough that later saturation is unchanged
  assign qc = (quo > DVD_W'(CLAMP)) ? 19'(CLAMP) : quo[18:0];
  assign qs = $signed({2'b00, qc});

  always_comb begin
    if (b_q == '0) begin
      if (a_q < 0) begin
        centre_d = CW'(32767);
      end else if (a_q > 0) begin
        centre_d = -CW'(32768);
      end else begin
        centre_d = CW'(HALF_W);
      end
    end else if (a_q[33] == b_q[33]) begin
      centre_d = CW'(HALF_W) - qs;
    end else begin
      centre_d = CW'(HALF_W) + qs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      left_q  <= '0;
      right_q <= '0;
    end else begin
      if (cmd_i.div_take && cmd_i.div_op == DIV_DEPTH) begin
        if (det_q == '0) begin
          depth_q <= '0;
        end else if (b_q[33] == det_q[32]) begin
          depth_q <= (quo > DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
        end else begin
          depth_q <= (quo > DVD_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                  : $signed(32'd0 - quo[31:0]);
        end
      end
      if (cmd_i.proj_commit) begin
        left_q  <= sat16(c22 - h22);
        right_q <= sat16(c22 + h22);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_take) begin
      unique case (cmd_i.div_op)
        DIV_CENTRE: centre_q <= centre_d;
        DIV_HEIGHT: begin
          if (depth_q == '0 || quo > DVD_W'(16'hFFFF)) begin
            half_q <= 15'h7FFF;
          end else begin
            half_q <= quo[15:1];
          end
        end
        DIV_TEX:    tex_q <= quo[5:0];
        default:    ;
      endcase
    end
  end

  // z-buffer, no reset: each column must be written before it is tested; the block does not enforce this
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take && kind_e'(kind_i) == KIND_WRITE) begin
      mem[column_i] <= wall_depth_i;
    end
    rd_q <= mem[col_q];
  end

  assign in_extent = (col_s >= left_q) && (col_s < right_q);
  assign in_screen = 32'(col_q) < SCREEN_W;
  assign draw_d    = in_extent && (depth_q > 0) && in_screen &&
                     (depth_q < $signed({16'd0, rd_q}));

  assign c22  = centre_q;
  assign h22  = $signed({7'd0, half_q});
  assign hz22 = $signed({12'd0, hud_top_i[10:1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.proj_commit || cmd_i.test_commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.proj_commit) begin
      centre_x_o    <= sat16(c22);
      left_x_o      <= sat16(c22 - h22);
      right_x_o     <= sat16(c22 + h22);
      top_y_o       <= sat16(hz22 - h22);
      bottom_y_o    <= sat16(hz22 + h22);
      sq_distance_o <= sq_q;
      behind_o      <= (depth_q <= 0);
      tex_column_o  <= '0;
      draw_o        <= 1'b0;
    end else if (cmd_i.test_commit) begin
      centre_x_o    <= '0;
      left_x_o      <= '0;
      right_x_o     <= '0;
      top_y_o       <= '0;
      bottom_y_o    <= '0;
      sq_distance_o <= '0;
      behind_o      <= 1'b0;
      tex_column_o  <= in_extent ? tex_q : 6'd0;
      draw_o        <= draw_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_hold  = out_valid_q && out_stall_i;

  a_take_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_take |-> div_done)
    else $error("quotient taken before divider finished");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.proj_commit || cmd_i.test_commit) |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while held");

endmodule

FILE: rtl/sprite_camera_projection_top.sv
// a depth write is done at its transfer; a projection result is registered after the
// multiply, the sum and three divisions in turn (depth, centre, height), a test result after
// one texture-column division; the shared divider resolves one quotient bit per cycle
// one item in flight: a write leaves the controller idle; after a project or test item
// no transfer is taken until its result is committed, which waits while a result is held
// reset clears control and sprite depth/extent, loads camera defaults; z-buffer not cleared
module sprite_camera_projection_top
  import spc_pkg::*;
#(
  parameter int SCREEN_W = SCREEN_W_DEF,
  parameter int TEX_RES  = TEX_RES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [9:0]         column_i,
  input  logic [15:0]        wall_depth_i,
  input  logic [15:0]        entity_x_i,
  input  logic [15:0]        entity_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] centre_x_o,
  output logic signed [15:0] left_x_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] top_y_o,
  output logic signed [15:0] bottom_y_o,
  output logic [33:0]        sq_distance_o,
  output logic               behind_o,
  output logic [5:0]         tex_column_o,
  output logic               draw_o
);

  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [15:0]        player_x_q, player_y_q;
  logic [10:0]        view_height_q, hud_top_q;
  logic               wr_en;
  reg_e               idx;
  spc_cmd_t           cmd;
  spc_sts_t           sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q       <= 16'sd16384;
      dir_y_q       <= '0;
      plane_x_q     <= '0;
      plane_y_q     <= 16'sd10813;
      player_x_q    <= '0;
      player_y_q    <= '0;
      view_height_q <= 11'd480;
      hud_top_q     <= 11'd400;
    end else if (wr_en) begin
      unique case (idx)
        REG_DIR_X:       dir_x_q       <= pwdata[15:0];
        REG_DIR_Y:       dir_y_q       <= pwdata[15:0];
        REG_PLANE_X:     plane_x_q     <= pwdata[15:0];
        REG_PLANE_Y:     plane_y_q     <= pwdata[15:0];
        REG_PLAYER_X:    player_x_q    <= pwdata[15:0];
        REG_PLAYER_Y:    player_y_q    <= pwdata[15:0];
        REG_VIEW_HEIGHT: view_height_q <= pwdata[10:0];
        REG_HUD_TOP:     hud_top_q     <= pwdata[10:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIR_X:       prdata = {16'd0, dir_x_q};
      REG_DIR_Y:       prdata = {16'd0, dir_y_q};
      REG_PLANE_X:     prdata = {16'd0, plane_x_q};
      REG_PLANE_Y:     prdata = {16'd0, plane_y_q};
      REG_PLAYER_X:    prdata = {16'd0, player_x_q};
      REG_PLAYER_Y:    prdata = {16'd0, player_y_q};
      REG_VIEW_HEIGHT: prdata = {21'd0, view_height_q};
      REG_HUD_TOP:     prdata = {21'd0, hud_top_q};
      default:         prdata = '0;
    endcase
  end

  spc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  spc_dp #(
    .SCREEN_W (SCREEN_W),
    .TEX_RES  (TEX_RES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .dir_x_i       (dir_x_q),
    .dir_y_i       (dir_y_q),
    .plane_x_i     (plane_x_q),
    .plane_y_i     (plane_y_q),
    .player_x_i    (player_x_q),
    .player_y_i    (player_y_q),
    .view_height_i (view_height_q),
    .hud_top_i     (hud_top_q),
    .kind_i        (kind_i),
    .column_i      (column_i),
    .wall_depth_i  (wall_depth_i),
    .entity_x_i    (entity_x_i),
    .entity_y_i    (entity_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .centre_x_o    (centre_x_o),
    .left_x_o      (left_x_o),
    .right_x_o     (right_x_o),
    .top_y_o       (top_y_o),
    .bottom_y_o    (bottom_y_o),
    .sq_distance_o (sq_distance_o),
    .behind_o      (behind_o),
    .tex_column_o  (tex_column_o),
    .draw_o        (draw_o)
  );

endmodule
